// ----- src/icsv_pkg.sv -----
// ----------------------------------------------------------------------------
// icsv_pkg
// shared types and constants for the image container stream validator
// ----------------------------------------------------------------------------
package icsv_pkg;

    // width and height must stay below 2**DIM_BITS
    localparam int DIM_BITS    = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result status codes; busy doubles as "no error"
    typedef enum logic [3:0] {
        ST_BUSY    = 4'd0,
        ST_VALID   = 4'd1,
        ST_MAGIC   = 4'd2,
        ST_RANGE   = 4'd3,
        ST_SIZE    = 4'd4,
        ST_CAP_NUL = 4'd5,
        ST_TAG_NL  = 4'd6,
        ST_HDR_NUL = 4'd7,
        ST_TRUNC   = 4'd8,
        ST_TRAIL   = 4'd9,
        ST_OVERRUN = 4'd10
    } t_status;

    // what a byte was taken for
    typedef enum logic [2:0] {
        BK_MAGIC   = 3'd0,
        BK_FIELD   = 3'd1,
        BK_CAPTION = 3'd2,
        BK_TAG     = 3'd3,
        BK_PIXEL   = 3'd4,
        BK_IGNORED = 3'd5
    } t_kind;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } t_in_beat;

    // one result beat
    typedef struct packed {
        logic [3:0] status;
        logic [2:0] byte_kind;
        logic [7:0] pixel_byte;
        logic [1:0] channel;
    } t_out_beat;

    // classified byte, handed from the front end to the back end
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        final_byte;
        logic [63:0] pos_next;   // file position of this byte plus one
        logic        magic_ok;   // byte matches the magic character at its place
        logic        magic_last; // byte is the last magic character
        logic [1:0]  fidx;       // which size field, when in the field area
        logic [2:0]  fbyte;      // byte lane within the size field
    } t_cls;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cls head;
    } t_queue_status;

endpackage

// ----- src/icsv_front.sv -----
// ----------------------------------------------------------------------------
// icsv_front
// accepts input beats, tracks the file position and classifies each byte
// ----------------------------------------------------------------------------
module icsv_front
    import icsv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_data,
    input  logic     i_full,
    output logic     o_stall,
    output logic     o_push,
    output t_cls     o_cls
);

    localparam logic [5:0] FIELD_START = 6'd4;

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h43;
            2'd1: c = 8'h49;
            2'd2: c = 8'h46;
            2'd3: c = 8'h46;
        endcase
        return c;
    endfunction

    logic [63:0] r_pos;
    logic [63:0] cur_pos;
    logic [5:0]  rel;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        // a first byte restarts the file at position zero
        cur_pos = i_data.first_byte ? 64'd0 : r_pos;
        rel     = cur_pos[5:0] - FIELD_START;

        o_cls.data_byte  = i_data.data_byte;
        o_cls.first_byte = i_data.first_byte;
        o_cls.final_byte = i_data.final_byte;
        o_cls.pos_next   = cur_pos + 64'd1;
        o_cls.magic_ok   = i_data.data_byte == magic_char(cur_pos[1:0]);
        o_cls.magic_last = cur_pos == 64'd3;
        o_cls.fidx       = rel[4:3];
        o_cls.fbyte      = rel[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= o_cls.pos_next;
        end
    end

endmodule

// ----- src/icsv_queue.sv -----
// ----------------------------------------------------------------------------
// icsv_queue
// short fifo of classified bytes between front and back end
// ----------------------------------------------------------------------------
module icsv_queue
    import icsv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cls          i_cls,
    input  logic          i_pop,
    output logic          o_full,
    output t_queue_status o_q
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    t_cls              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full     = r_cnt == FULL_CNT;
    assign o_q.valid  = r_cnt != '0;
    assign o_q.head   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cls;
        end
    end

endmodule

// ----- src/icsv_back.sv -----
// ----------------------------------------------------------------------------
// icsv_back
// parse state machine: field decode, size checks and result register
// ----------------------------------------------------------------------------
module icsv_back
    import icsv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_q,
    output logic          o_pop,
    output logic          o_valid,
    output t_out_beat     o_data,
    input  logic          i_stall
);

    localparam int W3_W  = DIM_BITS + 2;
    localparam int MUL_W = W3_W + 8;
    localparam int ACC_W = 2 * DIM_BITS + 2;

    localparam logic [63:0] MIN_HDR      = 64'd37;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;
    localparam logic [7:0]  CHAR_NL      = 8'h0A;
    localparam logic [2:0]  LAST_LANE    = 3'd7;
    localparam logic [1:0]  LAST_CHANNEL = 2'd2;

    localparam logic [1:0] F_HDR     = 2'd0;
    localparam logic [1:0] F_CONTENT = 2'd1;
    localparam logic [1:0] F_WIDTH   = 2'd2;
    localparam logic [1:0] F_HEIGHT  = 2'd3;

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_FIELDS  = 8'b0000_0010,
        PH_CAPTION = 8'b0000_0100,
        PH_TAGS    = 8'b0000_1000,
        PH_PIXELS  = 8'b0001_0000,
        PH_DONE    = 8'b0010_0000,
        PH_ERROR   = 8'b0100_0000,
        PH_ENDED   = 8'b1000_0000
    } t_phase;

    t_phase              r_phase, n_phase, ph;
    t_status             r_err, n_err, err;
    logic [1:0]          r_chan, n_chan;
    logic [63:0]         r_hdr, n_hdr;
    logic [63:0]         r_content, n_content;
    logic [63:0]         r_total, n_total;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [W3_W-1:0]     r_w3, n_w3;
    logic [ACC_W-1:0]    r_prod, n_prod;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_out_valid;
    t_out_beat           r_out, res;
    t_cls                it;
    logic [63:0]         wide;
    logic                range_bad;
    logic                lane_last;
    logic [MUL_W-1:0]    mul;

    assign it      = i_q.head;
    assign o_pop   = i_q.valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        ph        = it.first_byte ? PH_MAGIC : r_phase;
        n_phase   = ph;
        n_err     = r_err;
        n_chan    = r_chan;
        n_hdr     = r_hdr;
        n_content = r_content;
        n_total   = r_total;
        n_width   = r_width;
        n_height  = r_height;
        n_w3      = r_w3;
        n_prod    = r_prod;
        n_acc     = r_acc;
        err       = ST_BUSY;

        res.status     = ST_BUSY;
        res.byte_kind  = BK_IGNORED;
        res.pixel_byte = '0;
        res.channel    = '0;

        wide      = 64'(it.data_byte) << {it.fbyte, 3'b000};
        range_bad = |wide[63:DIM_BITS];
        lane_last = it.fbyte == LAST_LANE;
        mul       = MUL_W'(r_w3) * MUL_W'(it.data_byte);

        unique case (ph)
            PH_MAGIC: begin
                res.byte_kind = BK_MAGIC;
                // magic is only reached from reset or a first byte
                n_chan    = '0;
                n_hdr     = '0;
                n_content = '0;
                n_width   = '0;
                n_height  = '0;
                n_w3      = '0;
                n_prod    = '0;
                n_acc     = '0;
                if (!it.magic_ok) begin
                    err = ST_MAGIC;
                end else if (it.magic_last) begin
                    n_phase = PH_FIELDS;
                end
            end
            PH_FIELDS: begin
                res.byte_kind = BK_FIELD;
                unique case (it.fidx)
                    F_HDR: begin
                        n_hdr = r_hdr | wide;
                        if (lane_last && (n_hdr[63] || n_hdr < MIN_HDR)) begin
                            err = ST_RANGE;
                        end
                    end
                    F_CONTENT: begin
                        n_content = r_content | wide;
                        if (lane_last && (n_content[63] || n_content == '0)) begin
                            err = ST_RANGE;
                        end
                    end
                    F_WIDTH: begin
                        n_total = r_hdr + r_content;
                        if (range_bad) begin
                            err = ST_RANGE;
                        end else begin
                            n_width = r_width | wide[DIM_BITS-1:0];
                            n_w3    = {2'b00, n_width} + {1'b0, n_width, 1'b0};
                            if (lane_last && n_width == '0) begin
                                err = ST_RANGE;
                            end
                        end
                    end
                    F_HEIGHT: begin
                        // product lags one byte; upper lanes are zero when valid
                        n_prod = ACC_W'(mul) << {it.fbyte, 3'b000};
                        n_acc  = r_acc + r_prod;
                        if (range_bad) begin
                            err = ST_RANGE;
                        end else begin
                            n_height = r_height | wide[DIM_BITS-1:0];
                            if (lane_last) begin
                                priority if (n_height == '0) begin
                                    err = ST_RANGE;
                                end else if (r_content != 64'(r_acc)) begin
                                    err = ST_SIZE;
                                end else begin
                                    n_phase = PH_CAPTION;
                                end
                            end
                        end
                    end
                endcase
            end
            PH_CAPTION: begin
                res.byte_kind = BK_CAPTION;
                priority if (it.data_byte == CHAR_NUL) begin
                    err = ST_CAP_NUL;
                end else if (it.data_byte == CHAR_NL) begin
                    n_phase = (it.pos_next == r_hdr) ? PH_PIXELS : PH_TAGS;
                end else if (it.pos_next == r_hdr) begin
                    err = ST_OVERRUN;
                end else begin
                    n_phase = PH_CAPTION;
                end
            end
            PH_TAGS: begin
                res.byte_kind = BK_TAG;
                priority if (it.data_byte == CHAR_NL) begin
                    err = ST_TAG_NL;
                end else if (it.pos_next == r_hdr) begin
                    if (it.data_byte != CHAR_NUL) begin
                        err = ST_HDR_NUL;
                    end else begin
                        n_phase = PH_PIXELS;
                    end
                end else begin
                    n_phase = PH_TAGS;
                end
            end
            PH_PIXELS: begin
                res.byte_kind  = BK_PIXEL;
                res.pixel_byte = it.data_byte;
                res.channel    = r_chan;
                n_chan         = (r_chan == LAST_CHANNEL) ? 2'd0 : r_chan + 2'd1;
                if (it.pos_next == r_total) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE, PH_ENDED: begin
                err = ST_TRAIL;
            end
            PH_ERROR: begin
                res.status = r_err;
            end
            default: begin
                res.status = r_err;
            end
        endcase

        priority if (err != ST_BUSY) begin
            n_phase    = PH_ERROR;
            n_err      = err;
            res.status = err;
        end else if (n_phase != PH_ERROR && it.final_byte) begin
            if (n_phase == PH_DONE) begin
                n_phase    = PH_ENDED;
                res.status = ST_VALID;
            end else begin
                n_phase    = PH_ERROR;
                n_err      = ST_TRUNC;
                res.status = ST_TRUNC;
            end
        end else begin
            n_err = n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_err       <= ST_BUSY;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_err       <= n_err;
                r_chan      <= n_chan;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hdr     <= n_hdr;
            r_content <= n_content;
            r_total   <= n_total;
            r_width   <= n_width;
            r_height  <= n_height;
            r_w3      <= n_w3;
            r_prod    <= n_prod;
            r_acc     <= n_acc;
            r_out     <= res;
        end
    end

endmodule

// ----- src/image_container_stream_validator_unit.sv -----
// ----------------------------------------------------------------------------
// image_container_stream_validator_unit
// byte-stream validator for a simple rgb image container
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                  beat type
//  -------  ---  -------------------------  ----------
//  input    in   i_in_valid / o_in_stall    t_in_beat
//  result   out  o_out_valid / i_out_stall  t_out_beat
//
//  one byte per clock sustained while i_out_stall is low, one result beat per input beat
//  an accepted beat is written into a queue slot, then into the result register
//  the rate is set by the parse step of the back end
//  input stall rises only when the two-entry queue is full
//  synchronous active-low reset; no clearing pass, ready right after reset
//
module image_container_stream_validator_unit
    import icsv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    // front to queue
    logic          push;
    t_cls          cls;
    logic          q_full;

    // queue to back
    t_queue_status q_stat;
    logic          pop;

    // position tracking and per-byte classification
    icsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cls   (cls)
    );

    // decouples the input stall from the result stall
    icsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (cls),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_q     (q_stat)
    );

    // parse state, size checks and result register
    icsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_stat),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
